@@ rtl/ttgs_pkg.sv @@
// Shared types, constants and register codes of the two-type token Gibbs sampler.
package ttgs_pkg;

  // Fixed field widths of the input and result transfers.
  localparam int SAMPLE_W = 10;
  localparam int POS_W    = 6;
  localparam int TERM_W   = 12;
  localparam int CLASS_W  = 3;
  localparam int FRAC_W   = 16;

  // Count widths and saturation limits.
  localparam int CNT_W  = 17;
  localparam int SCNT_W = 7;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [SCNT_W-1:0] SCNT_MAX = '1;

  // Configuration register widths and map.
  localparam int HYP_W   = 16;
  localparam int VOCAB_W = 13;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_BETA_BKG   = 3'd0;
  localparam logic [2:0] REG_BETA_CLS   = 3'd1;
  localparam logic [2:0] REG_GAMMA_BKG  = 3'd2;
  localparam logic [2:0] REG_GAMMA_CLS  = 3'd3;
  localparam logic [2:0] REG_VOCAB_SIZE = 3'd4;

  localparam logic [HYP_W-1:0]   BETA_RST  = 16'd26;
  localparam logic [HYP_W-1:0]   GAMMA_RST = 16'd256;
  localparam logic [VOCAB_W-1:0] VOCAB_RST = 13'd4096;

  // Command codes.
  localparam logic CMD_INIT     = 1'b0;
  localparam logic CMD_RESAMPLE = 1'b1;

  // Default sizes of the stores.
  localparam int NUM_CLASSES_DEF = 8;
  localparam int VOCAB_SIZE_DEF  = 4096;
  localparam int NUM_SAMPLES_DEF = 1024;
  localparam int MAX_TERMS_DEF   = 64;

  // Wide multiplier operand widths.
  localparam int MA_W = 64;
  localparam int MB_W = 32;
  localparam int MP_W = MA_W + MB_W;

  typedef struct packed {
    logic [HYP_W-1:0]   beta_bkg;
    logic [HYP_W-1:0]   beta_cls;
    logic [HYP_W-1:0]   gamma_bkg;
    logic [HYP_W-1:0]   gamma_cls;
    logic [VOCAB_W-1:0] vocab_size;
  } ttgs_cfg_t;

endpackage

@@ rtl/ttgs_regs.sv @@
// Configuration register file behind the APB-style port.
module ttgs_regs
  import ttgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output ttgs_cfg_t          cfg_o
);

  ttgs_cfg_t   cfg_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[PADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta_bkg   <= BETA_RST;
      cfg_r.beta_cls   <= BETA_RST;
      cfg_r.gamma_bkg  <= GAMMA_RST;
      cfg_r.gamma_cls  <= GAMMA_RST;
      cfg_r.vocab_size <= VOCAB_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BETA_BKG:   cfg_r.beta_bkg   <= cfg_pwdata[HYP_W-1:0];
        REG_BETA_CLS:   cfg_r.beta_cls   <= cfg_pwdata[HYP_W-1:0];
        REG_GAMMA_BKG:  cfg_r.gamma_bkg  <= cfg_pwdata[HYP_W-1:0];
        REG_GAMMA_CLS:  cfg_r.gamma_cls  <= cfg_pwdata[HYP_W-1:0];
        REG_VOCAB_SIZE: cfg_r.vocab_size <= cfg_pwdata[VOCAB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BETA_BKG:   cfg_prdata = PDATA_W'(cfg_r.beta_bkg);
      REG_BETA_CLS:   cfg_prdata = PDATA_W'(cfg_r.beta_cls);
      REG_GAMMA_BKG:  cfg_prdata = PDATA_W'(cfg_r.gamma_bkg);
      REG_GAMMA_CLS:  cfg_prdata = PDATA_W'(cfg_r.gamma_cls);
      REG_VOCAB_SIZE: cfg_prdata = PDATA_W'(cfg_r.vocab_size);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/ttgs_mul.sv @@
// Two-pass 64 x 32 multiplier built on one registered 32 x 32 product.
module ttgs_mul
  import ttgs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [MA_W-1:0] a,
  input  logic [MB_W-1:0] b,
  output logic            done,
  output logic [MP_W-1:0] p
);

  localparam int HW = MA_W / 2;

  logic [1:0]         phase_r;
  logic               done_r;
  logic [HW-1:0]      a_hi_r;
  logic [MB_W-1:0]    b_r;
  logic [HW+MB_W-1:0] pp_r;
  logic [MP_W-1:0]    acc_r;
  logic [MP_W-1:0]    p_r;

  assign done = done_r;
  assign p    = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        2'd0: if (start) phase_r <= 2'd1;
        2'd1: phase_r <= 2'd2;
        2'd2: begin
          phase_r <= 2'd0;
          done_r  <= 1'b1;
        end
        default: phase_r <= 2'd0;
      endcase
    end
  end

  // Low half first, then the high half shifted into the running sum.
  always_ff @(posedge clk) begin
    case (phase_r)
      2'd0: if (start) begin
        a_hi_r <= a[MA_W-1:HW];
        b_r    <= b;
        pp_r   <= a[HW-1:0] * b;
      end
      2'd1: begin
        acc_r <= MP_W'(pp_r);
        pp_r  <= a_hi_r * b_r;
      end
      2'd2: p_r <= acc_r + {pp_r, {HW{1'b0}}};
      default: ;
    endcase
  end

endmodule

@@ rtl/ttgs_mem.sv @@
// Single-port-write, registered-read synchronous memory.
module ttgs_mem #(
  parameter  int DEPTH = 1024,
  parameter  int WIDTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/two_type_token_gibbs_sampler_unit.sv @@
// Top level of the two-type token Gibbs sampler: sequencer, count stores and decision.
//
// One token is handled at a time. After reset the block sweeps both count memories to zero,
// one row per cycle, over max(NUM_SAMPLES, VOCAB_SIZE) rows (4096 at the defaults); inputs
// stall during the sweep, configuration writes are taken throughout. An init token is
// accepted, read, updated and written back; a resample token also forms the eight products
// of the exact cross-multiplied comparison, which all go through one shared 64 x 32 multiplier
// in turn. When a size parameter is not a power of two, each token first reduces its indexes
// by conditional subtraction.
// The sample memory holds per sample the token type bits and the two per-sample counts; the
// term memory holds per term the background count and one count per class. Both are read
// once and written once per token, so successive tokens never overlap on an entry. A result
// waits in an output register; the next input transfer is taken while it waits.
module two_type_token_gibbs_sampler_unit
  import ttgs_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int VOCAB_SIZE  = VOCAB_SIZE_DEF,
  parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
  parameter int MAX_TERMS   = MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [SAMPLE_W-1:0] in_sample_index,
  input  logic [POS_W-1:0]    in_term_position,
  input  logic [TERM_W-1:0]   in_term_id,
  input  logic [CLASS_W-1:0]  in_class_id,
  input  logic [FRAC_W-1:0]   in_random_fraction,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_new_type,
  output logic                out_previous_type,
  // Configuration port.
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PADDR_W-1:0]  cfg_paddr,
  input  logic [PDATA_W-1:0]  cfg_pwdata,
  output logic [PDATA_W-1:0]  cfg_prdata,
  output logic                cfg_pready
);

  localparam int SAW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int TAW = (VOCAB_SIZE > 1)  ? $clog2(VOCAB_SIZE)  : 1;
  localparam int PW  = (MAX_TERMS > 1)   ? $clog2(MAX_TERMS)   : 1;
  localparam int KW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam int SROW_W = MAX_TERMS + 2 * SCNT_W;
  localparam int TROW_W = (1 + NUM_CLASSES) * CNT_W;
  localparam int SB_LO  = MAX_TERMS;
  localparam int SC_LO  = MAX_TERMS + SCNT_W;

  localparam int CLR_LEN = (NUM_SAMPLES > VOCAB_SIZE) ? NUM_SAMPLES : VOCAB_SIZE;
  localparam int CW      = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

  localparam bit NEED_MOD = ((NUM_SAMPLES & (NUM_SAMPLES - 1)) != 0) ||
                            ((MAX_TERMS & (MAX_TERMS - 1)) != 0) ||
                            ((VOCAB_SIZE & (VOCAB_SIZE - 1)) != 0) ||
                            ((NUM_CLASSES & (NUM_CLASSES - 1)) != 0);
  localparam logic [3:0] MOD_LAST = 4'(TERM_W - 1);

  // Product widths of the comparison.
  localparam int NX_W = CNT_W + 9;        // 256*count + prior
  localparam int N_W  = 2 * NX_W - 9;     // Nb, Nc
  localparam int D_W  = 30;               // Db, Dc
  localparam int L1_W = N_W + FRAC_W + 1; // Nb*(65536-f), f*Nc
  localparam int L_W  = L1_W + D_W;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MOD   = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_CALC  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_MWAIT = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;

  localparam logic [2:0] MS_NB = 3'd0;
  localparam logic [2:0] MS_NC = 3'd1;
  localparam logic [2:0] MS_VB = 3'd2;
  localparam logic [2:0] MS_VC = 3'd3;
  localparam logic [2:0] MS_L1 = 3'd4;
  localparam logic [2:0] MS_R1 = 3'd5;
  localparam logic [2:0] MS_L  = 3'd6;
  localparam logic [2:0] MS_R  = 3'd7;

  function automatic logic [31:0] mod_step(input logic [31:0] v, input logic [31:0] m,
                                           input logic [3:0] j);
    logic [31:0] sh;
    sh = m << j;
    mod_step = (v >= sh) ? v - sh : v;
  endfunction

  function automatic logic [CNT_W-1:0] inc17(input logic [CNT_W-1:0] v);
    inc17 = (v < CNT_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [CNT_W-1:0] dec17(input logic [CNT_W-1:0] v);
    dec17 = (v != '0) ? v - 1'b1 : v;
  endfunction

  function automatic logic [SCNT_W-1:0] inc7(input logic [SCNT_W-1:0] v);
    inc7 = (v < SCNT_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [SCNT_W-1:0] dec7(input logic [SCNT_W-1:0] v);
    dec7 = (v != '0) ? v - 1'b1 : v;
  endfunction

  ttgs_cfg_t cfg;

  ttgs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // Control state.
  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       clr_r, clr_nxt;
  logic [3:0]          modj_r, modj_nxt;
  logic [2:0]          mstep_r, mstep_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    bkg_total_r, bkg_total_nxt;
  logic [CNT_W-1:0]    class_totals_r [NUM_CLASSES];
  logic [CNT_W-1:0]    class_totals_nxt [NUM_CLASSES];

  // Token payload and working values.
  logic                cmd_r, cmd_nxt;
  logic [SAMPLE_W-1:0] s_r, s_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [TERM_W-1:0]   t_r, t_nxt;
  logic [CLASS_W-1:0]  k_r, k_nxt;
  logic [FRAC_W-1:0]   f_r, f_nxt;
  logic                prev_r, prev_nxt;
  logic                type_r, type_nxt;
  logic [SCNT_W-1:0]   sb_r, sb_nxt, sc_r, sc_nxt;
  logic [CNT_W-1:0]    wb_r, wb_nxt, wc_r, wc_nxt, bt_r, bt_nxt, ct_r, ct_nxt;
  logic [N_W-1:0]      nb_r, nb_nxt, nc_r, nc_nxt;
  logic [D_W-1:0]      db_r, db_nxt, dc_r, dc_nxt;
  logic [L1_W-1:0]     l1_r, l1_nxt, r1_r, r1_nxt;
  logic [L_W-1:0]      lp_r, lp_nxt, rp_r, rp_nxt;
  logic                out_new_r, out_new_nxt, out_prev_r, out_prev_nxt;

  // Index views of the token.
  logic [SAW-1:0]      s_idx;
  logic [PW-1:0]       pos_idx;
  logic [TAW-1:0]      t_idx;
  logic [KW-1:0]       k_idx;

  // Memory ports.
  logic                smem_re, smem_we, tmem_re, tmem_we;
  logic [SAW-1:0]      smem_waddr;
  logic [TAW-1:0]      tmem_waddr;
  logic [SROW_W-1:0]   smem_rdata, smem_wdata;
  logic [TROW_W-1:0]   tmem_rdata, tmem_wdata;

  // Multiplier.
  logic                mul_start, mul_done;
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [MP_W-1:0]     mul_p;

  logic [NX_W-1:0]     xb, xc, yb, yc;
  logic                wb_go;

  assign s_idx   = SAW'(s_r);
  assign pos_idx = PW'(pos_r);
  assign t_idx   = TAW'(t_r);
  assign k_idx   = KW'(k_r);

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_new_type      = out_new_r;
  assign out_previous_type = out_prev_r;

  assign wb_go = !out_valid_r || !out_stall;

  ttgs_mem #(.DEPTH(NUM_SAMPLES), .WIDTH(SROW_W)) u_smem (
    .clk   (clk),
    .re    (smem_re),
    .raddr (s_idx),
    .rdata (smem_rdata),
    .we    (smem_we),
    .waddr (smem_waddr),
    .wdata (smem_wdata)
  );

  ttgs_mem #(.DEPTH(VOCAB_SIZE), .WIDTH(TROW_W)) u_tmem (
    .clk   (clk),
    .re    (tmem_re),
    .raddr (t_idx),
    .rdata (tmem_rdata),
    .we    (tmem_we),
    .waddr (tmem_waddr),
    .wdata (tmem_wdata)
  );

  ttgs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Factors of the two collapsed weights, all in units of 1/256.
  assign xb = NX_W'({sb_r, 8'd0}) + NX_W'(cfg.gamma_bkg);
  assign xc = NX_W'({sc_r, 8'd0}) + NX_W'(cfg.gamma_cls);
  assign yb = NX_W'({wb_r, 8'd0}) + NX_W'(cfg.beta_bkg);
  assign yc = NX_W'({wc_r, 8'd0}) + NX_W'(cfg.beta_cls);

  // Operand selection of the shared multiplier.
  always_comb begin
    case (mstep_r)
      MS_NB: begin mul_a = MA_W'(xb);              mul_b = MB_W'(yb);            end
      MS_NC: begin mul_a = MA_W'(xc);              mul_b = MB_W'(yc);            end
      MS_VB: begin mul_a = MA_W'(cfg.vocab_size);  mul_b = MB_W'(cfg.beta_bkg);  end
      MS_VC: begin mul_a = MA_W'(cfg.vocab_size);  mul_b = MB_W'(cfg.beta_cls);  end
      MS_L1: begin
        mul_a = MA_W'(nb_r);
        mul_b = MB_W'(17'h10000 - {1'b0, f_r});
      end
      MS_R1: begin mul_a = MA_W'(nc_r);            mul_b = MB_W'(f_r);           end
      MS_L:  begin mul_a = MA_W'(l1_r);            mul_b = MB_W'(dc_r);          end
      MS_R:  begin mul_a = MA_W'(r1_r);            mul_b = MB_W'(db_r);          end
      default: begin mul_a = '0;                   mul_b = '0;                   end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    modj_nxt      = modj_r;
    mstep_nxt     = mstep_r;
    out_valid_nxt = out_valid_r;
    bkg_total_nxt = bkg_total_r;
    for (int i = 0; i < NUM_CLASSES; i++) class_totals_nxt[i] = class_totals_r[i];
    cmd_nxt  = cmd_r;
    s_nxt    = s_r;
    pos_nxt  = pos_r;
    t_nxt    = t_r;
    k_nxt    = k_r;
    f_nxt    = f_r;
    prev_nxt = prev_r;
    type_nxt = type_r;
    sb_nxt   = sb_r;
    sc_nxt   = sc_r;
    wb_nxt   = wb_r;
    wc_nxt   = wc_r;
    bt_nxt   = bt_r;
    ct_nxt   = ct_r;
    nb_nxt   = nb_r;
    nc_nxt   = nc_r;
    db_nxt   = db_r;
    dc_nxt   = dc_r;
    l1_nxt   = l1_r;
    r1_nxt   = r1_r;
    lp_nxt   = lp_r;
    rp_nxt   = rp_r;
    out_new_nxt  = out_new_r;
    out_prev_nxt = out_prev_r;
    smem_re    = 1'b0;
    tmem_re    = 1'b0;
    smem_we    = 1'b0;
    tmem_we    = 1'b0;
    smem_waddr = s_idx;
    tmem_waddr = t_idx;
    smem_wdata = smem_rdata;
    tmem_wdata = tmem_rdata;
    mul_start  = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLR: begin
        smem_waddr = SAW'(clr_r);
        tmem_waddr = TAW'(clr_r);
        smem_wdata = '0;
        tmem_wdata = '0;
        smem_we    = (32'(clr_r) < NUM_SAMPLES);
        tmem_we    = (32'(clr_r) < VOCAB_SIZE);
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CW'(CLR_LEN - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          s_nxt     = in_sample_index;
          pos_nxt   = in_term_position;
          t_nxt     = in_term_id;
          k_nxt     = in_class_id;
          f_nxt     = in_random_fraction;
          modj_nxt  = MOD_LAST;
          state_nxt = NEED_MOD ? ST_MOD : ST_RD;
        end
      end
      ST_MOD: begin
        // One bit of each index reduction per cycle, most significant first.
        s_nxt   = SAMPLE_W'(mod_step(32'(s_r), 32'(NUM_SAMPLES), modj_r));
        pos_nxt = POS_W'(mod_step(32'(pos_r), 32'(MAX_TERMS), modj_r));
        t_nxt   = TERM_W'(mod_step(32'(t_r), 32'(VOCAB_SIZE), modj_r));
        k_nxt   = CLASS_W'(mod_step(32'(k_r), 32'(NUM_CLASSES), modj_r));
        modj_nxt = modj_r - 1'b1;
        if (modj_r == 4'd0) state_nxt = ST_RD;
      end
      ST_RD: begin
        smem_re   = 1'b1;
        tmem_re   = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        prev_nxt = smem_rdata[pos_idx];
        sb_nxt   = smem_rdata[SB_LO +: SCNT_W];
        sc_nxt   = smem_rdata[SC_LO +: SCNT_W];
        wb_nxt   = tmem_rdata[0 +: CNT_W];
        wc_nxt   = tmem_rdata[CNT_W * (32'(k_idx) + 1) +: CNT_W];
        bt_nxt   = bkg_total_r;
        ct_nxt   = class_totals_r[k_idx];
        if (cmd_r == CMD_RESAMPLE) begin
          // Take the token out of the counts of its stored type.
          if (!smem_rdata[pos_idx]) begin
            sb_nxt = dec7(smem_rdata[SB_LO +: SCNT_W]);
            wb_nxt = dec17(tmem_rdata[0 +: CNT_W]);
            bt_nxt = dec17(bkg_total_r);
          end else begin
            sc_nxt = dec7(smem_rdata[SC_LO +: SCNT_W]);
            wc_nxt = dec17(tmem_rdata[CNT_W * (32'(k_idx) + 1) +: CNT_W]);
            ct_nxt = dec17(class_totals_r[k_idx]);
          end
          mstep_nxt = MS_NB;
          state_nxt = ST_MUL;
        end else begin
          type_nxt  = f_r[FRAC_W-1];
          state_nxt = ST_WB;
        end
      end
      ST_MUL: begin
        mul_start = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          case (mstep_r)
            MS_NB: nb_nxt = mul_p[N_W-1:0];
            MS_NC: nc_nxt = mul_p[N_W-1:0];
            MS_VB: db_nxt = mul_p[D_W-1:0] + D_W'({bt_r, 8'd0});
            MS_VC: dc_nxt = mul_p[D_W-1:0] + D_W'({ct_r, 8'd0});
            MS_L1: l1_nxt = mul_p[L1_W-1:0];
            MS_R1: r1_nxt = mul_p[L1_W-1:0];
            MS_L:  lp_nxt = mul_p[L_W-1:0];
            MS_R:  rp_nxt = mul_p[L_W-1:0];
            default: ;
          endcase
          mstep_nxt = mstep_r + 1'b1;
          state_nxt = (mstep_r == MS_R) ? ST_CMP : ST_MUL;
        end
      end
      ST_CMP: begin
        // Background wins only when its weighted side is strictly larger.
        type_nxt  = (lp_r <= rp_r);
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (wb_go) begin
          smem_we = 1'b1;
          tmem_we = 1'b1;
          smem_wdata[pos_idx]             = type_r;
          smem_wdata[SB_LO +: SCNT_W]     = type_r ? sb_r : inc7(sb_r);
          smem_wdata[SC_LO +: SCNT_W]     = type_r ? inc7(sc_r) : sc_r;
          tmem_wdata[0 +: CNT_W]          = type_r ? wb_r : inc17(wb_r);
          tmem_wdata[CNT_W * (32'(k_idx) + 1) +: CNT_W] = type_r ? inc17(wc_r) : wc_r;
          bkg_total_nxt                   = type_r ? bt_r : inc17(bt_r);
          class_totals_nxt[k_idx]         = type_r ? inc17(ct_r) : ct_r;
          out_valid_nxt = 1'b1;
          out_new_nxt   = type_r;
          out_prev_nxt  = prev_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      modj_r      <= '0;
      mstep_r     <= MS_NB;
      out_valid_r <= 1'b0;
      bkg_total_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) class_totals_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      modj_r      <= modj_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
      bkg_total_r <= bkg_total_nxt;
      for (int i = 0; i < NUM_CLASSES; i++) class_totals_r[i] <= class_totals_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    s_r        <= s_nxt;
    pos_r      <= pos_nxt;
    t_r        <= t_nxt;
    k_r        <= k_nxt;
    f_r        <= f_nxt;
    prev_r     <= prev_nxt;
    type_r     <= type_nxt;
    sb_r       <= sb_nxt;
    sc_r       <= sc_nxt;
    wb_r       <= wb_nxt;
    wc_r       <= wc_nxt;
    bt_r       <= bt_nxt;
    ct_r       <= ct_nxt;
    nb_r       <= nb_nxt;
    nc_r       <= nc_nxt;
    db_r       <= db_nxt;
    dc_r       <= dc_nxt;
    l1_r       <= l1_nxt;
    r1_r       <= r1_nxt;
    lp_r       <= lp_nxt;
    rp_r       <= rp_nxt;
    out_new_r  <= out_new_nxt;
    out_prev_r <= out_prev_nxt;
  end

  // An accepted transfer always leaves the idle state on the next edge.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted transfer did not start processing");

  // A new result only appears together with the write-back of its token.
  a_result_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(smem_we) && $past(tmem_we)))
    else $error("result raised without a write-back");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MWAIT))
    else $error("multiplier result arrived outside its wait state");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the two-type token Gibbs sampler unit.
`timescale 1ns / 1ps

module tb_top;
  import ttgs_pkg::*;

  // One token occurrence as presented on the input channel.
  typedef struct {
    logic              command;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]  pos;
    logic [TERM_W-1:0] term;
    logic [CLASS_W-1:0] cls;
    logic [FRAC_W-1:0] frac;
  } token_t;

  // Type decision that the block must report for one token.
  typedef struct {
    logic new_type;
    logic previous_type;
  } type_pair_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_command;
  logic [SAMPLE_W-1:0] in_sample_index;
  logic [POS_W-1:0]    in_term_position;
  logic [TERM_W-1:0]   in_term_id;
  logic [CLASS_W-1:0]  in_class_id;
  logic [FRAC_W-1:0]   in_random_fraction;
  logic                out_valid;
  logic                out_stall;
  logic                out_new_type;
  logic                out_previous_type;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [PADDR_W-1:0]  cfg_paddr;
  logic [PDATA_W-1:0]  cfg_pwdata;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  two_type_token_gibbs_sampler_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_sample_index    (in_sample_index),
    .in_term_position   (in_term_position),
    .in_term_id         (in_term_id),
    .in_class_id        (in_class_id),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_new_type       (out_new_type),
    .out_previous_type  (out_previous_type),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Tokens waiting to be driven and type decisions waiting to come out.
  token_t     token_queue[$];
  type_pair_t type_queue[$];
  int         error_count = 0;

  // Mirror of the sampler state: hyperparameters, token types and all counts.
  logic [HYP_W-1:0]   beta_b = BETA_RST;
  logic [HYP_W-1:0]   beta_c = BETA_RST;
  logic [HYP_W-1:0]   gamma_b = GAMMA_RST;
  logic [HYP_W-1:0]   gamma_c = GAMMA_RST;
  logic [VOCAB_W-1:0] vocab_w = VOCAB_RST;
  bit                 token_type[NUM_SAMPLES_DEF*MAX_TERMS_DEF];
  bit [CNT_W-1:0]     term_bkg[VOCAB_SIZE_DEF];
  bit [CNT_W-1:0]     term_cls[VOCAB_SIZE_DEF*NUM_CLASSES_DEF];
  bit [SCNT_W-1:0]    sample_bkg[NUM_SAMPLES_DEF];
  bit [SCNT_W-1:0]    sample_cls[NUM_SAMPLES_DEF];
  bit [CNT_W-1:0]     class_total[NUM_CLASSES_DEF];
  bit [CNT_W-1:0]     bkg_total;

  // Adds or removes one token under the given type; counts saturate at both ends.
  task automatic update_counts(input bit cls_type, input int s, input int t, input int k,
                               input bit add);
    int ti;
    ti = t * NUM_CLASSES_DEF + k;
    if (!cls_type) begin
      if (add) begin
        if (term_bkg[t] != CNT_MAX) term_bkg[t]++;
        if (sample_bkg[s] != SCNT_MAX) sample_bkg[s]++;
        if (bkg_total != CNT_MAX) bkg_total++;
      end else begin
        if (term_bkg[t] != 0) term_bkg[t]--;
        if (sample_bkg[s] != 0) sample_bkg[s]--;
        if (bkg_total != 0) bkg_total--;
      end
    end else begin
      if (add) begin
        if (term_cls[ti] != CNT_MAX) term_cls[ti]++;
        if (sample_cls[s] != SCNT_MAX) sample_cls[s]++;
        if (class_total[k] != CNT_MAX) class_total[k]++;
      end else begin
        if (term_cls[ti] != 0) term_cls[ti]--;
        if (sample_cls[s] != 0) sample_cls[s]--;
        if (class_total[k] != 0) class_total[k]--;
      end
    end
  endtask

  // Works out the type decision for one accepted token and updates the mirror.
  task automatic predict_type(input token_t tk);
    int s, t, k, slot;
    bit prev_t, next_t;
    logic [63:0] nb, nc, db, dc;
    logic [127:0] lhs, rhs;
    type_pair_t r;
    s = int'(tk.sample);
    t = int'(tk.term);
    k = int'(tk.cls);
    slot = s * MAX_TERMS_DEF + int'(tk.pos);
    prev_t = token_type[slot];
    if (tk.command == CMD_INIT) begin
      // Init draws from the fraction alone and does not remove any earlier assignment.
      next_t = tk.frac >= 16'd32768;
    end else begin
      update_counts(prev_t, s, t, k, 1'b0);
      nb = (64'(sample_bkg[s]) * 256 + gamma_b) * (64'(term_bkg[t]) * 256 + beta_b);
      nc = (64'(sample_cls[s]) * 256 + gamma_c) *
           (64'(term_cls[t*NUM_CLASSES_DEF+k]) * 256 + beta_c);
      db = 64'(bkg_total) * 256 + 64'(vocab_w) * beta_b;
      dc = 64'(class_total[k]) * 256 + 64'(vocab_w) * beta_c;
      lhs = 128'(nb * (64'd65536 - tk.frac)) * 128'(dc);
      rhs = 128'(64'(tk.frac) * nc) * 128'(db);
      next_t = !(lhs > rhs);
    end
    update_counts(next_t, s, t, k, 1'b1);
    token_type[slot] = next_t;
    r.new_type = next_t;
    r.previous_type = prev_t;
    type_queue.push_back(r);
  endtask

  // Input side: a transfer is taken at the rising edge; the next token goes out
  // at the falling edge, in bursts separated by random gaps.
  bit token_taken = 0;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_type('{in_command, in_sample_index, in_term_position, in_term_id,
                     in_class_id, in_random_fraction});
      token_taken = 1;
    end
  end

  always @(negedge clk) begin
    token_t tk;
    if (!in_valid || token_taken) begin
      token_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (token_queue.size() != 0) begin
        tk = token_queue.pop_front();
        in_valid <= 1'b1;
        in_command <= tk.command;
        in_sample_index <= tk.sample;
        in_term_position <= tk.pos;
        in_term_id <= tk.term;
        in_class_id <= tk.cls;
        in_random_fraction <= tk.frac;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // A quarter of the bursts run without any gap afterwards.
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: the stall pattern switches at random among three modes: never stalling,
  // short random stalls and long stall runs.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(100, 600);
    end
    mode_left--;
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (stall_mode == 1 && $urandom_range(0, 1) == 0) begin
      out_stall <= 1'b1;
    end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_run = $urandom_range(5, 60);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each result transfer is checked against the oldest waiting decision.
  always @(posedge clk) begin
    type_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (type_queue.size() == 0) begin
        $display("%0t: unexpected result transfer, new_type %0b previous_type %0b",
                 $time, out_new_type, out_previous_type);
        error_count++;
      end else begin
        want = type_queue.pop_front();
        if (out_new_type !== want.new_type) begin
          $display("%0t: new_type expected %0b actual %0b", $time, want.new_type,
                   out_new_type);
          error_count++;
        end
        if (out_previous_type !== want.previous_type) begin
          $display("%0t: previous_type expected %0b actual %0b", $time,
                   want.previous_type, out_previous_type);
          error_count++;
        end
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_BETA_BKG:   beta_b = value[HYP_W-1:0];
      REG_BETA_CLS:   beta_c = value[HYP_W-1:0];
      REG_GAMMA_BKG:  gamma_b = value[HYP_W-1:0];
      REG_GAMMA_CLS:  gamma_c = value[HYP_W-1:0];
      REG_VOCAB_SIZE: vocab_w = value[VOCAB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic write_all(input int bb, input int bc, input int gb, input int gc,
                           input int vw);
    write_reg(REG_BETA_BKG, bb);
    write_reg(REG_BETA_CLS, bc);
    write_reg(REG_GAMMA_BKG, gb);
    write_reg(REG_GAMMA_CLS, gc);
    write_reg(REG_VOCAB_SIZE, vw);
  endtask

  task automatic add_token(input logic cmd, input int s, input int pos, input int t,
                           input int k, input int f);
    token_t tk;
    tk.command = cmd;
    tk.sample = SAMPLE_W'(s);
    tk.pos = POS_W'(pos);
    tk.term = TERM_W'(t);
    tk.cls = CLASS_W'(k);
    tk.frac = FRAC_W'(f);
    token_queue.push_back(tk);
  endtask

  // Random tokens crowd onto a few samples and terms so that the counts build up,
  // saturate and interact; the rest spread across every field value.
  task automatic add_random_tokens(input int n);
    int s, t, k;
    repeat (n) begin
      s = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 1023);
      t = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 4095);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : s % 8;
      add_token(($urandom_range(0, 99) < 35) ? CMD_INIT : CMD_RESAMPLE, s,
                $urandom_range(0, 63), t, k, $urandom_range(0, 65535));
    end
  endtask

  // Holds the sender back until every decision has come out, then lets the
  // longest token latency pass before the block is treated as idle.
  task automatic drain;
    while (!(token_queue.size() == 0 && !in_valid && type_queue.size() == 0))
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_INIT;
    in_sample_index = '0;
    in_term_position = '0;
    in_term_id = '0;
    in_class_id = '0;
    in_random_fraction = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings, written once explicitly.
    write_all(BETA_RST, BETA_RST, GAMMA_RST, GAMMA_RST, VOCAB_RST);
    // A resample of a token that was never assigned removes from empty counts.
    add_token(CMD_RESAMPLE, 5, 3, 9, 5, 30000);
    // The init threshold on both sides, at the extremes of every field.
    add_token(CMD_INIT, 0, 0, 0, 0, 0);
    add_token(CMD_INIT, 1023, 63, 4095, 7, 65535);
    add_token(CMD_INIT, 1, 1, 1, 1, 32767);
    add_token(CMD_INIT, 2, 2, 2, 2, 32768);
    // A token initialized three times is counted three times.
    add_token(CMD_INIT, 0, 0, 0, 0, 65535);
    add_token(CMD_INIT, 0, 0, 0, 0, 100);
    // Resamples at the extreme fractions.
    add_token(CMD_RESAMPLE, 0, 0, 0, 0, 0);
    add_token(CMD_RESAMPLE, 0, 0, 0, 0, 65535);
    add_token(CMD_RESAMPLE, 1023, 63, 4095, 7, 1);
    add_token(CMD_RESAMPLE, 1023, 63, 4095, 7, 65534);
    add_token(CMD_RESAMPLE, 1, 1, 1, 1, 32768);
    add_token(CMD_RESAMPLE, 2, 2, 2, 2, 32767);
    add_token(CMD_RESAMPLE, 5, 3, 9, 5, 30000);
    drain;
    add_random_tokens(80);
    drain;

    // Smallest smoothing, largest priors and a one-term vocabulary.
    write_all(1, 1, 65535, 65535, 1);
    add_random_tokens(80);
    drain;

    // Largest smoothing, smallest priors, the widest vocabulary register value.
    write_all(65535, 65535, 1, 1, 8191);
    add_random_tokens(80);
    drain;

    // Zero smoothing and an empty vocabulary: both denominators can vanish.
    write_all(0, 0, 0, $urandom_range(1, 65535), 0);
    add_random_tokens(60);
    drain;

    // Two phases at random settings.
    repeat (2) begin
      write_all($urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(1, 4096));
      add_random_tokens(100);
      drain;
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Covers the reset sweep and 500 slow resamples under long stalls.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
